// ===== sv/tou_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the time-of-use energy accumulator.
// Used by every module of the block; depends on nothing else.
package tou_pkg;

  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MINUTE_W   = 11;
  localparam int unsigned ENERGY_W   = 64;
  localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = MINUTE_W'(60);

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_START = 2'd0,
    CFG_HIGH_END   = 2'd1,
    CFG_MID_START  = 2'd2,
    CFG_MID_END    = 2'd3
  } tou_cfg_idx_t;

  typedef enum logic [1:0] {
    BKT_LOW  = 2'd0,
    BKT_MID  = 2'd1,
    BKT_HIGH = 2'd2
  } tou_tariff_t;

  // Which counters a date change clears before this word's energy is added.
  typedef struct packed {
    logic roll;
    logic clr_year;
    logic clr_month;
    logic clr_day;
  } tou_clr_t;

  typedef struct packed {
    logic [31:0]  power;
    logic [31:0]  dt;
    logic         add;
    tou_clr_t     clr;
    tou_tariff_t  bucket;
    logic         ack;
  } tou_s1_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] delta;
    tou_clr_t            clr;
    tou_tariff_t         bucket;
    logic                ack;
  } tou_s2_t;

  function automatic logic in_window(logic [MINUTE_W-1:0] start, logic [MINUTE_W-1:0] stop,
                                     logic [MINUTE_W-1:0] m);
    logic r;
    if (start <= stop) begin
      r = (m >= start) && (m < stop);
    end else begin
      r = (m >= start) || (m < stop);
    end
    return r;
  endfunction

  function automatic logic [ENERGY_W-1:0] sat_add(logic [ENERGY_W-1:0] a,
                                                  logic [ENERGY_W-1:0] d);
    logic [ENERGY_W-1:0] s;
    logic [ENERGY_W-1:0] r;
    s = a + d;
    r = s;
    // Overflow only when both operands share a sign that the sum lost.
    if ((a[ENERGY_W-1] == d[ENERGY_W-1]) && (s[ENERGY_W-1] != a[ENERGY_W-1])) begin
      r = a[ENERGY_W-1] ? ENERGY_MIN : ENERGY_MAX;
    end
    return r;
  endfunction

endpackage

// ===== sv/tou_energy_accumulator.sv =====
`timescale 1ns / 1ps
// Time-of-use energy accumulator, top level. An accepted word passes the input register, the
// product register and the counter and result register. Throughput is one word per cycle while
// out_ready is high; the 32x33 multiply and the 64-bit saturating adds each own one stage.
// A stalled result holds only the last stage; earlier bubbles still fill.
// Synchronous active-low reset clears the windows, date, tick, counters, flag and valids.
module tou_energy_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tou_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tou_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_sample_valid,
  input  logic [31:0]                         in_tick_ms,
  input  logic signed [31:0]                  in_power_mw,
  input  logic [13:0]                         in_year,
  input  logic [3:0]                          in_month,
  input  logic [4:0]                          in_day,
  input  logic [4:0]                          in_hour,
  input  logic [5:0]                          in_minute,
  input  logic                                in_ack_rollover,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_day,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_month,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_year,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_low,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_mid,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_high,
  output logic                                out_rollover_flag,
  output logic [1:0]                          out_tariff_bucket
);

  logic              s1_valid, s1_ready;
  logic              s2_valid, s2_ready;
  tou_pkg::tou_s1_t  s1_data;
  tou_pkg::tou_s2_t  s2_data;

  tou_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_valid (in_sample_valid),
    .in_tick_ms      (in_tick_ms),
    .in_power_mw     (in_power_mw),
    .in_year         (in_year),
    .in_month        (in_month),
    .in_day          (in_day),
    .in_hour         (in_hour),
    .in_minute       (in_minute),
    .in_ack_rollover (in_ack_rollover),
    .s1_valid        (s1_valid),
    .s1_ready        (s1_ready),
    .s1_data         (s1_data)
  );

  tou_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data)
  );

  tou_accum u_accum (
    .clk               (clk),
    .rst_n             (rst_n),
    .s2_valid          (s2_valid),
    .s2_ready          (s2_ready),
    .s2_data           (s2_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_energy_day    (out_energy_day),
    .out_energy_month  (out_energy_month),
    .out_energy_year   (out_energy_year),
    .out_energy_low    (out_energy_low),
    .out_energy_mid    (out_energy_mid),
    .out_energy_high   (out_energy_high),
    .out_rollover_flag (out_rollover_flag),
    .out_tariff_bucket (out_tariff_bucket)
  );

  // The pipeline is empty in the cycle after reset is asserted.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid && !s2_valid && !out_valid))
    else $error("pipeline not empty after reset");

  // A word waiting behind a stalled result must not be dropped.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && out_valid && !out_ready) |=> s2_valid)
    else $error("product stage lost a word under stall");

  // A word in the first stage must not be dropped while the product stage is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_ready) |=> s1_valid)
    else $error("input stage lost a word under stall");

  // Input can only be refused when the first stage holds a word that cannot move.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid && s2_valid && out_valid && !out_ready))
    else $error("input refused with room in the pipeline");

endmodule

// ===== sv/tou_front.sv =====
`timescale 1ns / 1ps
// Input stage: tariff window registers, stored date and previous tick, bucket select.
// Depends on tou_pkg.
module tou_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tou_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tou_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_sample_valid,
  input  logic [31:0]                     in_tick_ms,
  input  logic signed [31:0]              in_power_mw,
  input  logic [13:0]                     in_year,
  input  logic [3:0]                      in_month,
  input  logic [4:0]                      in_day,
  input  logic [4:0]                      in_hour,
  input  logic [5:0]                      in_minute,
  input  logic                            in_ack_rollover,
  output logic                            s1_valid,
  input  logic                            s1_ready,
  output tou_pkg::tou_s1_t                s1_data
);

  logic [tou_pkg::CFG_W-1:0] high_start_r, high_end_r, mid_start_r, mid_end_r;
  logic [13:0]               year_r;
  logic [3:0]                month_r;
  logic [4:0]                day_r;
  logic [31:0]               prev_tick_r;
  logic                      s1_valid_r, s1_valid_nxt;
  tou_pkg::tou_s1_t          s1_r, s1_nxt;

  logic                          accept;
  logic                          date_unset;
  logic                          year_ne, month_ne, day_ne;
  logic [tou_pkg::MINUTE_W-1:0]  mod;
  tou_pkg::tou_tariff_t          bucket;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mod = tou_pkg::MINUTE_W'(in_hour) * tou_pkg::MINUTES_PER_HOUR
        + tou_pkg::MINUTE_W'(in_minute);
    if (tou_pkg::in_window(high_start_r, high_end_r, mod)) begin
      bucket = tou_pkg::BKT_HIGH;
    end else if (tou_pkg::in_window(mid_start_r, mid_end_r, mod)) begin
      bucket = tou_pkg::BKT_MID;
    end else begin
      bucket = tou_pkg::BKT_LOW;
    end
  end

  assign date_unset = (year_r == '0) && (month_r == '0) && (day_r == '0);
  assign year_ne    = (in_year != year_r);
  assign month_ne   = (in_month != month_r);
  assign day_ne     = (in_day != day_r);

  always_comb begin
    s1_nxt                 = s1_r;
    s1_valid_nxt           = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt         = 1'b1;
      s1_nxt.power         = in_power_mw;
      s1_nxt.dt            = in_tick_ms - prev_tick_r;
      s1_nxt.add           = in_sample_valid && (prev_tick_r != '0);
      s1_nxt.clr.roll      = !date_unset && (year_ne || month_ne || day_ne);
      s1_nxt.clr.clr_day   = !date_unset && (year_ne || month_ne || day_ne);
      s1_nxt.clr.clr_month = !date_unset && (year_ne || month_ne);
      s1_nxt.clr.clr_year  = !date_unset && year_ne;
      s1_nxt.bucket        = bucket;
      s1_nxt.ack           = in_ack_rollover;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_start_r <= '0;
      high_end_r   <= '0;
      mid_start_r  <= '0;
      mid_end_r    <= '0;
      year_r       <= '0;
      month_r      <= '0;
      day_r        <= '0;
      prev_tick_r  <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_wr_en) begin
        case (tou_pkg::tou_cfg_idx_t'(cfg_index))
          tou_pkg::CFG_HIGH_START: high_start_r <= cfg_data;
          tou_pkg::CFG_HIGH_END:   high_end_r   <= cfg_data;
          tou_pkg::CFG_MID_START:  mid_start_r  <= cfg_data;
          tou_pkg::CFG_MID_END:    mid_end_r    <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        prev_tick_r <= in_tick_ms;
        year_r      <= in_year;
        month_r     <= in_month;
        day_r       <= in_day;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_r;

endmodule

// ===== sv/tou_mul.sv =====
`timescale 1ns / 1ps
// Product stage: power times elapsed milliseconds, registered.
// Depends on tou_pkg.
module tou_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  output logic              s1_ready,
  input  tou_pkg::tou_s1_t  s1_data,
  output logic              s2_valid,
  input  logic              s2_ready,
  output tou_pkg::tou_s2_t  s2_data
);

  logic              s2_valid_r;
  tou_pkg::tou_s2_t  s2_r;
  logic signed [tou_pkg::ENERGY_W-1:0] prod;
  logic              load;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;

  // The product of a signed 32-bit power and an unsigned 32-bit interval always fits 64 bits.
  assign prod = $signed(s1_data.power) * $signed({1'b0, s1_data.dt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_r.delta  <= s1_data.add ? prod : '0;
      s2_r.clr    <= s1_data.clr;
      s2_r.bucket <= s1_data.bucket;
      s2_r.ack    <= s1_data.ack;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_r;

endmodule

// ===== sv/tou_accum.sv =====
`timescale 1ns / 1ps
// Result stage: period and bucket counters with saturating add, rollover flag, result word.
// Depends on tou_pkg.
module tou_accum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s2_valid,
  output logic                                s2_ready,
  input  tou_pkg::tou_s2_t                    s2_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_day,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_month,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_year,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_low,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_mid,
  output logic signed [tou_pkg::ENERGY_W-1:0] out_energy_high,
  output logic                                out_rollover_flag,
  output logic [1:0]                          out_tariff_bucket
);

  localparam int unsigned NB = 3;

  logic                        out_valid_r;
  logic [tou_pkg::ENERGY_W-1:0] day_r, month_r, year_r;
  logic [tou_pkg::ENERGY_W-1:0] day_nxt, month_nxt, year_nxt;
  logic [tou_pkg::ENERGY_W-1:0] bkt_r [NB];
  logic [tou_pkg::ENERGY_W-1:0] bkt_nxt [NB];
  logic                        flag_r, flag_nxt;
  tou_pkg::tou_tariff_t        bucket_r;
  logic                        load;

  assign s2_ready = !out_valid_r || out_ready;
  assign load     = s2_valid && s2_ready;

  always_comb begin
    logic [tou_pkg::ENERGY_W-1:0] base;
    day_nxt   = tou_pkg::sat_add(s2_data.clr.clr_day ? '0 : day_r, s2_data.delta);
    month_nxt = tou_pkg::sat_add(s2_data.clr.clr_month ? '0 : month_r, s2_data.delta);
    year_nxt  = tou_pkg::sat_add(s2_data.clr.clr_year ? '0 : year_r, s2_data.delta);
    for (int b = 0; b < NB; b++) begin
      base = s2_data.clr.clr_day ? '0 : bkt_r[b];
      bkt_nxt[b] = (s2_data.bucket == tou_pkg::tou_tariff_t'(b))
                   ? tou_pkg::sat_add(base, s2_data.delta) : base;
    end
    // The acknowledge acts first, so a date change in the same word sets the flag again.
    flag_nxt = (flag_r && !s2_data.ack) || s2_data.clr.roll;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      day_r       <= '0;
      month_r     <= '0;
      year_r      <= '0;
      flag_r      <= 1'b0;
      for (int b = 0; b < NB; b++) begin
        bkt_r[b] <= '0;
      end
    end else begin
      if (s2_ready) begin
        out_valid_r <= s2_valid;
      end
      if (load) begin
        day_r   <= day_nxt;
        month_r <= month_nxt;
        year_r  <= year_nxt;
        flag_r  <= flag_nxt;
        for (int b = 0; b < NB; b++) begin
          bkt_r[b] <= bkt_nxt[b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bucket_r <= s2_data.bucket;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_energy_day    = $signed(day_r);
  assign out_energy_month  = $signed(month_r);
  assign out_energy_year   = $signed(year_r);
  assign out_energy_low    = $signed(bkt_r[tou_pkg::BKT_LOW]);
  assign out_energy_mid    = $signed(bkt_r[tou_pkg::BKT_MID]);
  assign out_energy_high   = $signed(bkt_r[tou_pkg::BKT_HIGH]);
  assign out_rollover_flag = flag_r;
  assign out_tariff_bucket = bucket_r;

endmodule
